[design/ljc_pkg.sv]
package ljc_pkg;

  localparam int CoordWidth = 24;
  localparam int AxisFrac = 14;
  localparam int AxisWidth = AxisFrac + 2;
  localparam int MagBits = 30;
  localparam int RootBits = MagBits + 1;
  localparam int SumWidth = 2 * MagBits + 2;
  localparam int SqrtSteps = RootBits;
  localparam int QuotBits = AxisFrac + 1;
  localparam int RemBits = RootBits + AxisFrac + 1;
  localparam int DiffWidth = CoordWidth + 1;
  localparam int Cross1Width = CoordWidth + AxisWidth + 1;
  localparam int Cross2Width = 2 * AxisWidth + 1;

  typedef struct packed {
    logic signed [CoordWidth-1:0] eye_x;
    logic signed [CoordWidth-1:0] eye_y;
    logic signed [CoordWidth-1:0] eye_z;
    logic signed [CoordWidth-1:0] target_x;
    logic signed [CoordWidth-1:0] target_y;
    logic signed [CoordWidth-1:0] target_z;
    logic signed [CoordWidth-1:0] up_hint_x;
    logic signed [CoordWidth-1:0] up_hint_y;
    logic signed [CoordWidth-1:0] up_hint_z;
  } cmd_t;

  typedef struct packed {
    logic signed [AxisWidth-1:0] right_x;
    logic signed [AxisWidth-1:0] right_y;
    logic signed [AxisWidth-1:0] right_z;
    logic signed [AxisWidth-1:0] upward_x;
    logic signed [AxisWidth-1:0] upward_y;
    logic signed [AxisWidth-1:0] upward_z;
    logic signed [AxisWidth-1:0] back_x;
    logic signed [AxisWidth-1:0] back_y;
    logic signed [AxisWidth-1:0] back_z;
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
  } result_t;

endpackage

[design/ljc_isqrt.sv]
module ljc_isqrt #(
  parameter int TW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [ljc_pkg::SumWidth-1:0] radicand,
  input  logic [TW-1:0]                in_tag,
  output logic                         out_valid,
  output logic [ljc_pkg::RootBits-1:0] root,
  output logic [TW-1:0]                out_tag
);
  import ljc_pkg::*;

  logic                valid [SqrtSteps];
  logic [SumWidth-1:0] x     [SqrtSteps];
  logic [SumWidth-1:0] res   [SqrtSteps];
  logic [TW-1:0]       tag   [SqrtSteps];

  logic                valid_in [SqrtSteps];
  logic [SumWidth-1:0] x_in     [SqrtSteps];
  logic [SumWidth-1:0] res_in   [SqrtSteps];
  logic [TW-1:0]       tag_in   [SqrtSteps];
  logic [SumWidth:0]   bit_val  [SqrtSteps];
  logic [SumWidth:0]   trial    [SqrtSteps];
  logic                take     [SqrtSteps];

  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      if (k == 0) begin
        valid_in[k] = in_valid;
        x_in[k] = radicand;
        res_in[k] = '0;
        tag_in[k] = in_tag;
      end else begin
        valid_in[k] = valid[k-1];
        x_in[k] = x[k-1];
        res_in[k] = res[k-1];
        tag_in[k] = tag[k-1];
      end
      bit_val[k] = (SumWidth+1)'(1) << (2 * (SqrtSteps - 1 - k));
      trial[k] = {1'b0, res_in[k]} + bit_val[k];
      take[k] = {1'b0, x_in[k]} >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SqrtSteps; k++) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else begin
        valid[k] <= valid_in[k];
      end
      if (take[k]) begin
        x[k] <= x_in[k] - trial[k][SumWidth-1:0];
        res[k] <= (res_in[k] >> 1) + bit_val[k][SumWidth-1:0];
      end else begin
        x[k] <= x_in[k];
        res[k] <= res_in[k] >> 1;
      end
      tag[k] <= tag_in[k];
    end
  end

  assign out_valid = valid[SqrtSteps-1];
  assign root = res[SqrtSteps-1][RootBits-1:0];
  assign out_tag = tag[SqrtSteps-1];

endmodule

[design/ljc_div.sv]
module ljc_div #(
  parameter int TW = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [ljc_pkg::RootBits-1:0]           divisor,
  input  logic [2:0][ljc_pkg::MagBits-1:0]       mag,
  input  logic [TW-1:0]                          in_tag,
  output logic                                   out_valid,
  output logic [2:0][ljc_pkg::QuotBits-1:0]      quot,
  output logic [TW-1:0]                          out_tag
);
  import ljc_pkg::*;

  logic                valid [QuotBits];
  logic [RootBits-1:0] dv    [QuotBits];
  logic [RemBits-1:0]  rem   [QuotBits][3];
  logic [QuotBits-1:0] q     [QuotBits][3];
  logic [TW-1:0]       tag   [QuotBits];

  logic                valid_in [QuotBits];
  logic [RootBits-1:0] dv_in    [QuotBits];
  logic [RemBits-1:0]  rem_in   [QuotBits][3];
  logic [QuotBits-1:0] q_in     [QuotBits][3];
  logic [TW-1:0]       tag_in   [QuotBits];
  logic [RemBits-1:0]  sub      [QuotBits];
  logic                take     [QuotBits][3];

  always_comb begin
    for (int k = 0; k < QuotBits; k++) begin
      if (k == 0) begin
        valid_in[k] = in_valid;
        dv_in[k] = divisor;
        tag_in[k] = in_tag;
        for (int j = 0; j < 3; j++) begin
          rem_in[k][j] = (RemBits'(mag[j]) << AxisFrac) + RemBits'(divisor >> 1);
          q_in[k][j] = '0;
        end
      end else begin
        valid_in[k] = valid[k-1];
        dv_in[k] = dv[k-1];
        tag_in[k] = tag[k-1];
        for (int j = 0; j < 3; j++) begin
          rem_in[k][j] = rem[k-1][j];
          q_in[k][j] = q[k-1][j];
        end
      end
      sub[k] = RemBits'(dv_in[k]) << (AxisFrac - k);
      for (int j = 0; j < 3; j++) begin
        take[k][j] = rem_in[k][j] >= sub[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QuotBits; k++) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else begin
        valid[k] <= valid_in[k];
      end
      dv[k] <= dv_in[k];
      tag[k] <= tag_in[k];
      for (int j = 0; j < 3; j++) begin
        if (take[k][j]) begin
          rem[k][j] <= rem_in[k][j] - sub[k];
          q[k][j] <= q_in[k][j] | (QuotBits'(1) << (AxisFrac - k));
        end else begin
          rem[k][j] <= rem_in[k][j];
          q[k][j] <= q_in[k][j];
        end
      end
    end
  end

  assign out_valid = valid[QuotBits-1];
  assign out_tag = tag[QuotBits-1];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      quot[j] = q[QuotBits-1][j];
    end
  end

endmodule

[design/ljc_norm.sv]
module ljc_norm #(
  parameter int VW = ljc_pkg::DiffWidth,
  parameter int TW = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [2:0][VW-1:0]                  vec,
  input  logic [TW-1:0]                       in_tag,
  output logic                                out_valid,
  output logic [2:0][ljc_pkg::AxisWidth-1:0]  axis,
  output logic [TW-1:0]                       out_tag
);
  import ljc_pkg::*;

  localparam int ShBits = $clog2(VW + 1);
  localparam int SqTw = 3 + 3 * MagBits + TW;
  localparam int DvTw = 3 + 1 + TW;

  logic                    v1, v2, v3, v4;
  logic [2:0][VW-1:0]      mag1;
  logic [2:0]              neg1, neg2, neg3, neg4;
  logic [TW-1:0]           tag1, tag2, tag3, tag4;
  logic [2:0][MagBits-1:0] sm2, sm3, sm4;
  logic [2*MagBits-1:0]    sq3 [3];
  logic [SumWidth-1:0]     sum4;

  logic [VW-1:0]           ormag;
  logic [ShBits-1:0]       sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    for (int j = 0; j < 3; j++) begin
      neg1[j] <= vec[j][VW-1];
      mag1[j] <= vec[j][VW-1] ? VW'(0) - vec[j] : vec[j];
      sm2[j] <= MagBits'(mag1[j] >> sh);
      sq3[j] <= (2*MagBits)'(sm2[j]) * (2*MagBits)'(sm2[j]);
    end
    tag1 <= in_tag;
    tag2 <= tag1;
    tag3 <= tag2;
    tag4 <= tag3;
    neg2 <= neg1;
    neg3 <= neg2;
    neg4 <= neg3;
    sm3 <= sm2;
    sm4 <= sm3;
    sum4 <= SumWidth'(sq3[0]) + SumWidth'(sq3[1]) + SumWidth'(sq3[2]);
  end

  // The highest set bit of the OR of the magnitudes is that of the largest one.
  always_comb begin
    ormag = mag1[0] | mag1[1] | mag1[2];
    sh = '0;
    for (int k = 0; k < VW; k++) begin
      if (k >= MagBits && ormag[k]) begin
        sh = ShBits'(k - MagBits + 1);
      end
    end
  end

  logic                    sq_valid;
  logic [RootBits-1:0]     root;
  logic [SqTw-1:0]         sq_tag;
  logic [2:0]              neg5;
  logic [2:0][MagBits-1:0] sm5;
  logic [TW-1:0]           tag5;

  ljc_isqrt #(.TW(SqTw)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .radicand  (sum4),
    .in_tag    ({neg4, sm4, tag4}),
    .out_valid (sq_valid),
    .root      (root),
    .out_tag   (sq_tag)
  );

  assign {neg5, sm5, tag5} = sq_tag;

  logic                     dv_valid;
  logic [2:0][QuotBits-1:0] quot;
  logic [DvTw-1:0]          dv_tag;
  logic [2:0]               neg6;
  logic                     zero6;
  logic [TW-1:0]            tag6;

  ljc_div #(.TW(DvTw)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .divisor   (root),
    .mag       (sm5),
    .in_tag    ({neg5, root == '0, tag5}),
    .out_valid (dv_valid),
    .quot      (quot),
    .out_tag   (dv_tag)
  );

  assign {neg6, zero6, tag6} = dv_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid;
    end
    out_tag <= tag6;
    for (int j = 0; j < 3; j++) begin
      if (zero6) begin
        axis[j] <= '0;
      end else if (neg6[j]) begin
        axis[j] <= AxisWidth'(0) - AxisWidth'(quot[j]);
      end else begin
        axis[j] <= AxisWidth'(quot[j]);
      end
    end
  end

endmodule

[design/look_at_camera_basis_top.sv]
// Throughput: one command per cycle while busy is low; busy is driven only by reset.
// Each of the three normalizations takes 51 stages, set by the 31-step square root
// and the 15-step divider; the two cross products take two stages each.
// Reset clears all valid bits; busy is high during reset and the cycle after.
// The receiver cannot stall: each result appears for exactly one cycle.
module look_at_camera_basis_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ljc_pkg::cmd_t    cmd,
  output logic             done,
  output ljc_pkg::result_t result
);
  import ljc_pkg::*;

  localparam int CW = CoordWidth;
  localparam int AW = AxisWidth;
  localparam int PW = CW + AW;
  localparam int Tag1W = 6 * CW;
  localparam int Tag2W = 3 * AW + 3 * CW;
  localparam int Tag3W = 6 * AW + 3 * CW;
  localparam logic signed [AW-1:0] One = AW'(1) << AxisFrac;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic                      v0;
  logic [2:0][DiffWidth-1:0] d0;
  logic [2:0][CW-1:0]        eye0, up0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    d0[0] <= {cmd.target_x[CW-1], cmd.target_x} - {cmd.eye_x[CW-1], cmd.eye_x};
    d0[1] <= {cmd.target_y[CW-1], cmd.target_y} - {cmd.eye_y[CW-1], cmd.eye_y};
    d0[2] <= {cmd.target_z[CW-1], cmd.target_z} - {cmd.eye_z[CW-1], cmd.eye_z};
    eye0 <= {cmd.eye_z, cmd.eye_y, cmd.eye_x};
    up0 <= {cmd.up_hint_z, cmd.up_hint_y, cmd.up_hint_x};
  end

  logic               n1_valid;
  logic [2:0][AW-1:0] fwd;
  logic [Tag1W-1:0]   n1_tag;
  logic [2:0][CW-1:0] eye1, up1;
  logic [2:0][AW-1:0] back1;

  ljc_norm #(.VW(DiffWidth), .TW(Tag1W)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .vec       (d0),
    .in_tag    ({up0, eye0}),
    .out_valid (n1_valid),
    .axis      (fwd),
    .out_tag   (n1_tag)
  );

  assign {up1, eye1} = n1_tag;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      back1[j] = AW'(0) - fwd[j];
    end
  end

  logic                       ca_valid, cb_valid;
  logic signed [PW-1:0]       pa [6];
  logic [2:0][AW-1:0]         back_a, back_b;
  logic [2:0][CW-1:0]         eye_a, eye_b;
  logic [2:0][Cross1Width-1:0] c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ca_valid <= 1'b0;
      cb_valid <= 1'b0;
    end else begin
      ca_valid <= n1_valid;
      cb_valid <= ca_valid;
    end
    pa[0] <= $signed(up1[1]) * $signed(back1[2]);
    pa[1] <= $signed(up1[2]) * $signed(back1[1]);
    pa[2] <= $signed(up1[2]) * $signed(back1[0]);
    pa[3] <= $signed(up1[0]) * $signed(back1[2]);
    pa[4] <= $signed(up1[0]) * $signed(back1[1]);
    pa[5] <= $signed(up1[1]) * $signed(back1[0]);
    back_a <= back1;
    eye_a <= eye1;
    for (int j = 0; j < 3; j++) begin
      c1[j] <= Cross1Width'(pa[2*j]) - Cross1Width'(pa[2*j+1]);
    end
    back_b <= back_a;
    eye_b <= eye_a;
  end

  logic               n2_valid;
  logic [2:0][AW-1:0] right2;
  logic [Tag2W-1:0]   n2_tag;
  logic [2:0][AW-1:0] back2;
  logic [2:0][CW-1:0] eye2;

  ljc_norm #(.VW(Cross1Width), .TW(Tag2W)) u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cb_valid),
    .vec       (c1),
    .in_tag    ({back_b, eye_b}),
    .out_valid (n2_valid),
    .axis      (right2),
    .out_tag   (n2_tag)
  );

  assign {back2, eye2} = n2_tag;

  logic                        da_valid, db_valid;
  logic signed [2*AW-1:0]      pb [6];
  logic [2:0][AW-1:0]          back_c, back_d, right_c, right_d;
  logic [2:0][CW-1:0]          eye_c, eye_d;
  logic [2:0][Cross2Width-1:0] c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      da_valid <= 1'b0;
      db_valid <= 1'b0;
    end else begin
      da_valid <= n2_valid;
      db_valid <= da_valid;
    end
    pb[0] <= $signed(back2[1]) * $signed(right2[2]);
    pb[1] <= $signed(back2[2]) * $signed(right2[1]);
    pb[2] <= $signed(back2[2]) * $signed(right2[0]);
    pb[3] <= $signed(back2[0]) * $signed(right2[2]);
    pb[4] <= $signed(back2[0]) * $signed(right2[1]);
    pb[5] <= $signed(back2[1]) * $signed(right2[0]);
    back_c <= back2;
    right_c <= right2;
    eye_c <= eye2;
    for (int j = 0; j < 3; j++) begin
      c2[j] <= Cross2Width'(pb[2*j]) - Cross2Width'(pb[2*j+1]);
    end
    back_d <= back_c;
    right_d <= right_c;
    eye_d <= eye_c;
  end

  logic [2:0][AW-1:0] upw3, back3, right3;
  logic [2:0][CW-1:0] eye3;
  logic [Tag3W-1:0]   n3_tag;

  ljc_norm #(.VW(Cross2Width), .TW(Tag3W)) u_norm_up (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (db_valid),
    .vec       (c2),
    .in_tag    ({right_d, back_d, eye_d}),
    .out_valid (done),
    .axis      (upw3),
    .out_tag   (n3_tag)
  );

  assign {right3, back3, eye3} = n3_tag;

  always_comb begin
    result.right_x = right3[0];
    result.right_y = right3[1];
    result.right_z = right3[2];
    result.upward_x = upw3[0];
    result.upward_y = upw3[1];
    result.upward_z = upw3[2];
    result.back_x = back3[0];
    result.back_y = back3[1];
    result.back_z = back3[2];
    result.pos_x = eye3[0];
    result.pos_y = eye3[1];
    result.pos_z = eye3[2];
  end

  a_busy_low: assert property (@(posedge clk) (!rst ##1 !rst) |-> !busy)
    else $error("busy high outside reset");

  a_back_unit: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.back_x <= One && result.back_x >= -One &&
              result.back_y <= One && result.back_y >= -One &&
              result.back_z <= One && result.back_z >= -One))
    else $error("back axis out of range");

  a_right_unit: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.right_x <= One && result.right_x >= -One &&
              result.right_y <= One && result.right_y >= -One &&
              result.right_z <= One && result.right_z >= -One))
    else $error("right axis out of range");

  a_up_unit: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.upward_x <= One && result.upward_x >= -One &&
              result.upward_y <= One && result.upward_y >= -One &&
              result.upward_z <= One && result.upward_z >= -One))
    else $error("upward axis out of range");

endmodule
